// File: rtl/abiod_pkg.sv
package abiod_pkg;

  localparam int unsigned SpriteBytesDefault = 96;

  localparam logic [15:0] AddrSpriteBase = 16'h9820;
  localparam logic [15:0] AddrSpriteLast = 16'h987f;
  localparam logic [15:0] AddrPlayerOne  = 16'hb000;
  localparam logic [15:0] AddrPlayerTwo  = 16'hb001;
  localparam logic [15:0] AddrStart      = 16'hb002;
  localparam logic [15:0] AddrDipA       = 16'hb004;
  localparam logic [15:0] AddrDipB       = 16'hb005;
  localparam logic [15:0] AddrNmiEnable  = 16'hb000;
  localparam logic [15:0] AddrMailboxWr  = 16'hb800;
  localparam logic [15:0] AddrSndStatus  = 16'hff00;
  localparam logic [15:0] AddrMailboxRd  = 16'h6000;
  localparam logic [7:0]  SndStatusByte  = 8'h7f;

  localparam logic [6:0] PortChip0 = 7'h00;
  localparam logic [6:0] PortChip1 = 7'h08;
  localparam logic [6:0] PortChip2 = 7'h40;

  localparam logic [1:0] Chip0 = 2'd0;
  localparam logic [1:0] Chip1 = 2'd1;
  localparam logic [1:0] Chip2 = 2'd2;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgDipA = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDipB = 1'b1;

  typedef enum logic [1:0] {
    KIND_MAIN_RD  = 2'd0,
    KIND_MAIN_WR  = 2'd1,
    KIND_SND_RD   = 2'd2,
    KIND_PORT_WR  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [6:0]  player_one_buttons;
    logic [6:0]  player_two_buttons;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_enabled;
    logic       psg_strobe;
    logic [1:0] psg_chip;
    logic       psg_is_data;
    logic [7:0] psg_byte;
  } result_t;

  typedef struct packed {
    logic       sprite_rd;
    logic       sprite_wr;
    logic       nmi_wr;
    logic       nmi_val;
    logic       mbox_wr;
    logic       mbox_clr;
    result_t    res;
  } dec_t;

  function automatic logic [7:0] pack_player(logic [6:0] b);
    pack_player = {3'b000, b[6], b[3], b[2], b[4], b[5]};
  endfunction

endpackage

// File: rtl/arcade_bus_io_decoder.sv
// Bus-side I/O decoder for a two-CPU arcade board.
// Each input transaction on in_item_i is one bus access: a main-CPU read or
// write, a sound-CPU read, or a sound-CPU port write. Every access returns
// exactly one result transaction on out_res_o carrying the read byte, the
// NMI-enable state after the access and the decoded sound-chip strobe.
// The user must load the DIP bytes through the configuration write port
// only while idle; the block does not enforce this. An access is decoded in
// the cycle it is accepted; register side effects and sprite RAM writes take
// place at that edge. The sprite RAM read is registered, after which the
// result is loaded into the output register. The block takes no new access
// until the result of the last one has moved into the output register.
// A new access is accepted while a finished result still waits in the output
// register; when the receiver stalls, the next result is held in the RAM
// read stage until the output register frees up.
// Reset clears the NMI flag, the sound mailbox, the DIP bytes and the sprite
// entry valid bits, so unwritten sprite bytes read as zero at once.
module arcade_bus_io_decoder #(
  parameter int unsigned SPRITE_BYTES = abiod_pkg::SpriteBytesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [abiod_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  abiod_pkg::item_t                in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output abiod_pkg::result_t              out_res_o
);

  localparam int unsigned IdxW = $clog2(SPRITE_BYTES);

  abiod_pkg::state_e  state_q, state_d;
  abiod_pkg::dec_t    dec;
  abiod_pkg::result_t part_q, part_d, out_q, out_d;
  logic [IdxW-1:0]    sprite_idx;
  logic [7:0]         dip_a_q, dip_b_q, mbox_q;
  logic               nmi_q;
  logic [SPRITE_BYTES-1:0] valid_q;
  logic               use_ram_q;
  logic               out_valid_q;
  logic               accept, out_load;
  logic [7:0]         ram_rdata;

  abiod_decode #(
    .SPRITE_BYTES(SPRITE_BYTES)
  ) u_decode (
    .item_i      (in_item_i),
    .dip_a_i     (dip_a_q),
    .dip_b_i     (dip_b_q),
    .mailbox_i   (mbox_q),
    .dec_o       (dec),
    .sprite_idx_o(sprite_idx)
  );

  abiod_ram #(
    .WIDTH(8),
    .DEPTH(SPRITE_BYTES)
  ) u_sprite_ram (
    .clk_i  (clk_i),
    .we_i   (accept & dec.sprite_wr),
    .re_i   (accept & dec.sprite_rd),
    .addr_i (sprite_idx),
    .wdata_i(in_item_i.write_data),
    .rdata_o(ram_rdata)
  );

  assign accept   = in_valid_i & in_ready_o;
  assign out_load = (state_q == abiod_pkg::ST_RESULT) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abiod_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = abiod_pkg::ST_RESULT;
        end
      end
      abiod_pkg::ST_RESULT: begin
        if (~out_valid_q | out_ready_i) begin
          state_d = abiod_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = abiod_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == abiod_pkg::ST_IDLE);
  end

  always_comb begin
    part_d = dec.res;
    out_d  = part_q;
    out_d.nmi_enabled = nmi_q;
    if (use_ram_q) begin
      out_d.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abiod_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      dip_a_q     <= 8'h00;
      dip_b_q     <= 8'h00;
      mbox_q      <= 8'h00;
      nmi_q       <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          abiod_pkg::CfgDipA: dip_a_q <= cfg_data_i;
          abiod_pkg::CfgDipB: dip_b_q <= cfg_data_i;
          default: dip_a_q <= dip_a_q;
        endcase
      end
      if (accept) begin
        if (dec.nmi_wr) begin
          nmi_q <= dec.nmi_val;
        end
        if (dec.mbox_wr) begin
          mbox_q <= in_item_i.write_data;
        end else if (dec.mbox_clr) begin
          mbox_q <= 8'h00;
        end
        if (dec.sprite_wr) begin
          valid_q[sprite_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      part_q    <= part_d;
      use_ram_q <= dec.sprite_rd & valid_q[sprite_idx];
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// File: rtl/abiod_ram.sv
module abiod_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = abiod_pkg::SpriteBytesDefault
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/abiod_decode.sv
module abiod_decode #(
  parameter int unsigned SPRITE_BYTES = abiod_pkg::SpriteBytesDefault
) (
  input  abiod_pkg::item_t                item_i,
  input  logic [7:0]                      dip_a_i,
  input  logic [7:0]                      dip_b_i,
  input  logic [7:0]                      mailbox_i,
  output abiod_pkg::dec_t                 dec_o,
  output logic [$clog2(SPRITE_BYTES)-1:0] sprite_idx_o
);

  localparam int unsigned IdxW = $clog2(SPRITE_BYTES);

  logic [15:0] offset;
  logic        in_window;
  logic [7:0]  port;

  assign offset    = item_i.address - abiod_pkg::AddrSpriteBase;
  assign in_window = (item_i.address >= abiod_pkg::AddrSpriteBase) &&
                     ({1'b0, offset} < 17'(SPRITE_BYTES));
  assign sprite_idx_o = offset[IdxW-1:0];
  assign port = item_i.address[7:0];

  always_comb begin
    dec_o = '0;
    unique case (item_i.kind)
      abiod_pkg::KIND_MAIN_RD: begin
        priority if (in_window) begin
          dec_o.sprite_rd = 1'b1;
        end else if (item_i.address == abiod_pkg::AddrPlayerOne) begin
          dec_o.res.read_data = abiod_pkg::pack_player(item_i.player_one_buttons);
        end else if (item_i.address == abiod_pkg::AddrPlayerTwo) begin
          dec_o.res.read_data = abiod_pkg::pack_player(item_i.player_two_buttons);
        end else if (item_i.address == abiod_pkg::AddrStart) begin
          dec_o.res.read_data = {4'b0000,
                                 item_i.player_two_buttons[1], item_i.player_one_buttons[1],
                                 item_i.player_two_buttons[0], item_i.player_one_buttons[0]};
        end else if (item_i.address == abiod_pkg::AddrDipA) begin
          dec_o.res.read_data = dip_a_i;
        end else if (item_i.address == abiod_pkg::AddrDipB) begin
          dec_o.res.read_data = dip_b_i;
        end else begin
          dec_o.res.read_data = 8'h00;
        end
      end
      abiod_pkg::KIND_MAIN_WR: begin
        priority if (in_window) begin
          dec_o.sprite_wr = 1'b1;
        end else if (item_i.address == abiod_pkg::AddrNmiEnable) begin
          dec_o.nmi_wr  = 1'b1;
          dec_o.nmi_val = (item_i.write_data != 8'h00);
        end else if (item_i.address == abiod_pkg::AddrMailboxWr) begin
          dec_o.mbox_wr = 1'b1;
        end else begin
          dec_o.mbox_wr = 1'b0;
        end
      end
      abiod_pkg::KIND_SND_RD: begin
        priority if (item_i.address == abiod_pkg::AddrSndStatus) begin
          dec_o.res.read_data = abiod_pkg::SndStatusByte;
        end else if (item_i.address == abiod_pkg::AddrMailboxRd) begin
          dec_o.res.read_data = mailbox_i;
          dec_o.mbox_clr      = 1'b1;
        end else begin
          dec_o.res.read_data = 8'h00;
        end
      end
      abiod_pkg::KIND_PORT_WR: begin
        unique case (port[7:1])
          abiod_pkg::PortChip0: begin
            dec_o.res.psg_strobe = 1'b1;
            dec_o.res.psg_chip   = abiod_pkg::Chip0;
          end
          abiod_pkg::PortChip1: begin
            dec_o.res.psg_strobe = 1'b1;
            dec_o.res.psg_chip   = abiod_pkg::Chip1;
          end
          abiod_pkg::PortChip2: begin
            dec_o.res.psg_strobe = 1'b1;
            dec_o.res.psg_chip   = abiod_pkg::Chip2;
          end
          default: begin
            dec_o.res.psg_strobe = 1'b0;
          end
        endcase
        if (dec_o.res.psg_strobe) begin
          dec_o.res.psg_is_data = port[0];
          dec_o.res.psg_byte    = item_i.write_data;
        end
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule
